// ----- rtl/lr2x_pkg.sv -----
// shared types and constants for the lr2 crossover filter
// no dependencies; used by lr2x_ctrl, lr2x_mac and lr2_crossover_filter
package lr2x_pkg;

	localparam int FRAC_BITS_DEF    = 30;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int COEF_W           = 30;
	localparam int FIELD_W          = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_S1_FF,
		ST_S1_FB,
		ST_S1_ACC,
		ST_S2_FB,
		ST_S2_FF,
		ST_S2_ACC,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic idle;
		logic mul_fb;
		logic sec2;
		logic acc_init;
		logic acc_fin;
		logic sum2_load;
		logic done;
	} seq_ctl_t;

endpackage

// ----- rtl/lr2_crossover_filter.sv -----
// second-order linkwitz-riley crossover, top level
// depends on lr2x_pkg, lr2x_ctrl and lr2x_mac
//
// usage:
//   input channel in_valid/in_stall carries one sample_in beat; the low
//   SAMPLE_WIDTH bits are taken as a signed sample with FRAC_BITS fraction bits
//   output channel out_valid/out_stall carries low_band and high_band, both
//   sign-extended to 32 bits; high_band is the negated highpass, so
//   low_band + high_band is a first-order allpass
//   cfg_wr_en/cfg_wr_data write coef_a0; write it only while the block is idle;
//   values above one half are clamped to one half, b1 = 1 - 2*a0 is derived
// timing:
//   a beat accepted in idle steps through S1_FF, S1_FB, S1_ACC, S2_FB, S2_FF,
//   S2_ACC and DONE; in_stall stays high in all of them, so the next sample
//   is taken only once the last has gone to the output register. the steps
//   come from the single shared multiplier: four products, two per section,
//   plus one accumulate/round step per section and one step for the high band
// reset:
//   arst_n clears coefficient, filter history and the output valid
// stall:
//   a finished beat waits in the output register; the next sample is accepted
//   meanwhile and its result waits in the last step until the register frees
module lr2_crossover_filter #(
	parameter int FRAC_BITS    = lr2x_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH = lr2x_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lr2x_pkg::COEF_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lr2x_pkg::FIELD_W-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lr2x_pkg::FIELD_W-1:0] low_band,
	output logic signed [lr2x_pkg::FIELD_W-1:0] high_band
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int H_W  = SAMPLE_WIDTH + 3;
	localparam int CW   = lr2x_pkg::COEF_W;
	localparam int FW   = lr2x_pkg::FIELD_W;
	localparam logic [CW-1:0] A0_MAX = CW'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

	lr2x_pkg::seq_ctl_t ctl;

	// configuration and filter history
	logic [CW-1:0]          coef_q;
	logic signed [SW-1:0]   prev_in_q;
	logic signed [SW-1:0]   s1_prev_q;
	logic signed [SW-1:0]   s2_prev_q;

	// per-sample working registers
	logic [FRAC_BITS-1:0]   a0_q;
	logic [FRAC_BITS:0]     b1_q;
	logic signed [SW-1:0]   x_q;
	logic signed [SW:0]     sum_q;
	logic signed [SW-1:0]   lp1_q;
	logic signed [SW-1:0]   lp2_q;

	// output register
	logic                   out_valid_q;
	logic signed [FW-1:0]   low_q;
	logic signed [FW-1:0]   high_q;

	logic                   accept;
	logic                   out_free;
	logic signed [SW-1:0]   x_in;
	logic [FRAC_BITS-1:0]   a0_eff;
	logic signed [SW-1:0]   y1_sel;
	logic signed [SW-1:0]   mac_res;
	logic signed [H_W-1:0]  hi_sum;
	logic                   hi_ovf;
	logic signed [SW-1:0]   hi_sat;

	assign accept   = in_valid && ctl.idle;
	assign in_stall = !ctl.idle;
	assign out_free = !out_valid_q || !out_stall;

	assign x_in   = sample_in[SW-1:0];
	// clamp a0 to one half so the feedback coefficient never goes negative
	assign a0_eff = (coef_q > A0_MAX) ? A0_MAX[FRAC_BITS-1:0] : coef_q[FRAC_BITS-1:0];
	assign y1_sel = ctl.sec2 ? s2_prev_q : s1_prev_q;

	lr2x_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctl      (ctl)
	);

	lr2x_mac #(
		.FRAC_BITS    (FRAC_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mac (
		.clk (clk),
		.ctl (ctl),
		.sum (sum_q),
		.y1  (y1_sel),
		.a0  (a0_q),
		.b1  (b1_q),
		.res (mac_res)
	);

	// high band: 2*lp1 - x - lp2, clamped to the sample range
	assign hi_sum = (H_W'(lp1_q) <<< 1) - H_W'(x_q) - H_W'(lp2_q);
	assign hi_ovf = (hi_sum[H_W-1:SW-1] != {(H_W-SW+1){1'b0}}) &&
	                (hi_sum[H_W-1:SW-1] != {(H_W-SW+1){1'b1}});

	always_comb begin
		if (hi_ovf) begin
			hi_sat = hi_sum[H_W-1] ? SMP_MIN : SMP_MAX;
		end else begin
			hi_sat = hi_sum[SW-1:0];
		end
	end

	// control state and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q      <= '0;
			prev_in_q   <= '0;
			s1_prev_q   <= '0;
			s2_prev_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				coef_q <= cfg_wr_data;
			end
			if (ctl.done) begin
				// history moves on only once the beat is handed to the output
				prev_in_q   <= x_q;
				s1_prev_q   <= lp1_q;
				s2_prev_q   <= lp2_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_in;
			a0_q  <= a0_eff;
			b1_q  <= ONE_Q - {a0_eff, 1'b0};
			// section one pre-add: x + x_prev
			sum_q <= (SW+1)'(x_in) + (SW+1)'(prev_in_q);
		end else if (ctl.sum2_load) begin
			// section two pre-add: lp1 + previous lp1
			sum_q <= (SW+1)'(lp1_q) + (SW+1)'(s1_prev_q);
		end
		if (ctl.acc_fin && !ctl.sec2) begin
			lp1_q <= mac_res;
		end
		if (ctl.acc_fin && ctl.sec2) begin
			lp2_q <= mac_res;
		end
		if (ctl.done) begin
			low_q  <= FW'(lp2_q);
			high_q <= FW'(hi_sat);
		end
	end

	assign out_valid = out_valid_q;
	assign low_band  = low_q;
	assign high_band = high_q;

endmodule

// ----- rtl/lr2x_ctrl.sv -----
// step sequencer for the crossover filter
// depends on lr2x_pkg (seq_state_t, seq_ctl_t)
module lr2x_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output lr2x_pkg::seq_ctl_t   ctl
);

	lr2x_pkg::seq_state_t state_q;
	lr2x_pkg::seq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lr2x_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		unique case (state_q)
			lr2x_pkg::ST_IDLE: begin
				ctl.idle = 1'b1;
				if (in_valid) begin
					state_d = lr2x_pkg::ST_S1_FF;
				end
			end
			lr2x_pkg::ST_S1_FF: begin
				state_d = lr2x_pkg::ST_S1_FB;
			end
			lr2x_pkg::ST_S1_FB: begin
				ctl.mul_fb   = 1'b1;
				ctl.acc_init = 1'b1;
				state_d      = lr2x_pkg::ST_S1_ACC;
			end
			lr2x_pkg::ST_S1_ACC: begin
				ctl.acc_fin = 1'b1;
				state_d     = lr2x_pkg::ST_S2_FB;
			end
			lr2x_pkg::ST_S2_FB: begin
				ctl.mul_fb    = 1'b1;
				ctl.sec2      = 1'b1;
				ctl.sum2_load = 1'b1;
				state_d       = lr2x_pkg::ST_S2_FF;
			end
			lr2x_pkg::ST_S2_FF: begin
				ctl.sec2     = 1'b1;
				ctl.acc_init = 1'b1;
				state_d      = lr2x_pkg::ST_S2_ACC;
			end
			lr2x_pkg::ST_S2_ACC: begin
				ctl.sec2    = 1'b1;
				ctl.acc_fin = 1'b1;
				state_d     = lr2x_pkg::ST_DONE;
			end
			lr2x_pkg::ST_DONE: begin
				// wait here until the output register can take the beat
				if (out_free) begin
					ctl.done = 1'b1;
					state_d  = lr2x_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lr2x_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/lr2x_mac.sv -----
// shared multiplier, accumulator and round/saturate unit
// depends on lr2x_pkg (seq_ctl_t, default widths)
module lr2x_mac #(
	parameter int FRAC_BITS    = lr2x_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH = lr2x_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  lr2x_pkg::seq_ctl_t            ctl,
	input  logic signed [SAMPLE_WIDTH:0]  sum,
	input  logic signed [SAMPLE_WIDTH-1:0] y1,
	input  logic [FRAC_BITS-1:0]          a0,
	input  logic [FRAC_BITS:0]            b1,
	output logic signed [SAMPLE_WIDTH-1:0] res
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int ACC_W = SAMPLE_WIDTH + FRAC_BITS + 3;
	localparam int R_W   = ACC_W - FRAC_BITS;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

	logic signed [SW:0]          mul_a;
	logic signed [FRAC_BITS+1:0] mul_b;
	logic signed [ACC_W-1:0]     prod_d;
	logic signed [ACC_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     acc_sum;
	logic signed [R_W-1:0]       shr;
	logic                        ovf;

	// feed-forward term a0*(x + x_prev) or feedback term b1*y_prev
	always_comb begin
		if (ctl.mul_fb) begin
			mul_a = (SW+1)'(y1);
			mul_b = $signed({1'b0, b1});
		end else begin
			mul_a = sum;
			mul_b = $signed({2'b00, a0});
		end
	end

	assign prod_d = ACC_W'(mul_a) * ACC_W'(mul_b);

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (ctl.acc_init) begin
			acc_q <= prod_q + RND_HALF;
		end
	end

	// second product joins, then floor shift and clamp to the sample range
	assign acc_sum = acc_q + prod_q;
	assign shr     = acc_sum[ACC_W-1:FRAC_BITS];
	assign ovf     = (shr[R_W-1:SW-1] != {(R_W-SW+1){1'b0}}) &&
	                 (shr[R_W-1:SW-1] != {(R_W-SW+1){1'b1}});

	always_comb begin
		if (ovf) begin
			res = shr[R_W-1] ? SMP_MIN : SMP_MAX;
		end else begin
			res = shr[SW-1:0];
		end
	end

endmodule
